// ===== rtl/fractional_delay_line_macros.svh =====
// assertion macros for the fractional delay line
// expects clk and rst_n in the scope of each use
`ifndef FRACTIONAL_DELAY_LINE_MACROS_SVH
`define FRACTIONAL_DELAY_LINE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fdl_pkg.sv =====
// shared constants and register codes for the fractional delay line
// no dependencies
package fdl_pkg;

  // build defaults
  localparam int DEF_MAX_DEPTH    = 4096;
  localparam int DEF_SAMPLE_WIDTH = 24;

  // register port geometry
  localparam int CFG_DATA_W = 32;
  localparam int PADDR_W    = 4;

  // register field widths
  localparam int LEN_FIELD_W = 13;
  localparam int FRAC_W      = 8;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 12;

  // total fraction bits of the blended, gained product
  localparam int PROD_SHIFT = GAIN_FRAC + FRAC_W;

  // register reset values
  localparam logic [LEN_FIELD_W-1:0] RST_LINE_LENGTH = LEN_FIELD_W'(4096);
  localparam logic [LEN_FIELD_W-1:0] RST_DELAY_WHOLE = LEN_FIELD_W'(1);
  localparam logic [FRAC_W-1:0]      RST_DELAY_FRAC  = '0;
  localparam logic [GAIN_W-1:0]      RST_GAIN        = GAIN_W'(4096);

  // register map, word index
  typedef enum logic [1:0] {
    REG_LINE_LENGTH    = 2'd0,
    REG_DELAY_WHOLE    = 2'd1,
    REG_DELAY_FRACTION = 2'd2,
    REG_MAKEUP_GAIN    = 2'd3
  } fdl_reg_t;

endpackage

// ===== rtl/fdl_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fdl_mul.sv =====
// shared signed multiplier with registered product
// no dependencies
module fdl_mul #(
  parameter int AW = 32,
  parameter int BW = 17
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic signed [AW+BW-1:0]   prod
);

  logic signed [AW+BW-1:0] prod_r;

  // one product per enabled cycle, held otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

// ===== rtl/fdl_regs.sv =====
// register file for the fractional delay line, apb-style write and read
// depends on fdl_pkg; derives the effective length and delay
module fdl_regs #(
  parameter int MAX_DEPTH = fdl_pkg::DEF_MAX_DEPTH,
  parameter int NW        = $clog2(MAX_DEPTH) + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fdl_pkg::PADDR_W-1:0]     paddr,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fdl_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [NW-1:0]                   eff_len,
  output logic [NW-1:0]                   eff_whole,
  output logic [fdl_pkg::FRAC_W-1:0]      eff_frac,
  output logic [fdl_pkg::GAIN_W-1:0]      gain
);

  import fdl_pkg::*;

  logic [LEN_FIELD_W-1:0] line_length_r;
  logic [LEN_FIELD_W-1:0] delay_whole_r;
  logic [FRAC_W-1:0]      delay_frac_r;
  logic [GAIN_W-1:0]      gain_r;

  fdl_reg_t reg_sel;
  logic     wr_en;
  logic [31:0] n32;
  logic [31:0] w32;
  logic [FRAC_W-1:0] f_eff;

  assign pready  = 1'b1;
  assign reg_sel = fdl_reg_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= RST_LINE_LENGTH;
      delay_whole_r <= RST_DELAY_WHOLE;
      delay_frac_r  <= RST_DELAY_FRAC;
      gain_r        <= RST_GAIN;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LINE_LENGTH:    line_length_r <= pwdata[LEN_FIELD_W-1:0];
        REG_DELAY_WHOLE:    delay_whole_r <= pwdata[LEN_FIELD_W-1:0];
        REG_DELAY_FRACTION: delay_frac_r  <= pwdata[FRAC_W-1:0];
        REG_MAKEUP_GAIN:    gain_r        <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      REG_LINE_LENGTH:    prdata = CFG_DATA_W'(line_length_r);
      REG_DELAY_WHOLE:    prdata = CFG_DATA_W'(delay_whole_r);
      REG_DELAY_FRACTION: prdata = CFG_DATA_W'(delay_frac_r);
      REG_MAKEUP_GAIN:    prdata = CFG_DATA_W'(gain_r);
      default:            prdata = '0;
    endcase
  end

  // effective length: zero acts as one, clamp to the store depth
  always_comb begin
    n32 = 32'(line_length_r);
    if (n32 == 32'd0) begin
      n32 = 32'd1;
    end
    if (n32 > 32'(MAX_DEPTH)) begin
      n32 = 32'(MAX_DEPTH);
    end
  end

  // effective delay: zero delay acts as one sample, long delays clamp
  always_comb begin
    w32   = 32'(delay_whole_r);
    f_eff = delay_frac_r;
    if (w32 == 32'd0 && f_eff == '0) begin
      w32 = 32'd1;
    end
    if (w32 > n32 || (w32 == n32 && f_eff != '0)) begin
      w32   = n32;
      f_eff = '0;
    end
  end

  assign eff_len   = n32[NW-1:0];
  assign eff_whole = w32[NW-1:0];
  assign eff_frac  = f_eff;
  assign gain      = gain_r;

endmodule

// ===== rtl/fdl_core.sv =====
// sequencer and datapath: two store reads, two passes through one multiplier
// depends on fdl_pkg, fdl_ram, fdl_mul and fractional_delay_line_macros.svh
`include "fractional_delay_line_macros.svh"

module fdl_core #(
  parameter int MAX_DEPTH    = fdl_pkg::DEF_MAX_DEPTH,
  parameter int SAMPLE_WIDTH = fdl_pkg::DEF_SAMPLE_WIDTH,
  parameter int NW           = $clog2(MAX_DEPTH) + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [SAMPLE_WIDTH-1:0]     in_sample_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [SAMPLE_WIDTH-1:0]     out_sample_out,
  input  logic [NW-1:0]               eff_len,
  input  logic [NW-1:0]               eff_whole,
  input  logic [fdl_pkg::FRAC_W-1:0]  eff_frac,
  input  logic [fdl_pkg::GAIN_W-1:0]  gain
);

  import fdl_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = $clog2(MAX_DEPTH);
  localparam int MAW = SW + FRAC_W;
  localparam int MBW = GAIN_W + 1;
  localparam int PRW = MAW + MBW;
  localparam int QW  = PRW - PROD_SHIFT;
  localparam logic signed [PRW-1:0] ROUND_HALF = PRW'(1) <<< (PROD_SHIFT - 1);
  localparam logic [SW-1:0] SAT_POS = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SAT_NEG = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDB,
    S_MUL1,
    S_MUL2,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [NW-1:0]  fill_r, fill_nxt;
  logic [PW-1:0]  prev_r, prev_nxt;
  logic           a_ok_r, a_ok_nxt;
  logic           b_ok_r, b_ok_nxt;
  logic [SW-1:0]  sample_r, sample_nxt;
  logic [SW-1:0]  a_r, a_nxt;
  logic [SW-1:0]  out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [PW-1:0]   wp_eff;
  logic [PW+1:0]   rp_sum;
  logic [PW+1:0]   rp_wrap;
  logic [PW-1:0]   rp;
  logic [PW-1:0]   prev;
  logic [PW-1:0]   raddr;
  logic [SW-1:0]   rdata;
  logic [SW-1:0]   b_val;
  logic [SW:0]     diff;
  logic [MAW-1:0]  blend;
  logic            ram_we;
  logic            mul_en;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PRW-1:0] prod;
  logic signed [PRW-1:0] acc;
  logic [QW-1:0]   q;
  logic [QW-SW:0]  q_top;
  logic [SW-1:0]   q_sat;
  logic            out_free;

  // sample store
  fdl_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_eff),
    .wdata(sample_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  // shared multiplier: blend product first, then gain
  fdl_mul #(
    .AW(MAW),
    .BW(MBW)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  // write position drops to zero when the line is shortened below it
  assign wp_eff = (NW'(wp_r) >= eff_len) ? '0 : wp_r;

  // read position and the entry before it, wrapped at the line length
  assign rp_sum  = (PW+2)'(wp_eff) + (PW+2)'(eff_len) - (PW+2)'(eff_whole);
  assign rp_wrap = (rp_sum >= (PW+2)'(eff_len)) ? rp_sum - (PW+2)'(eff_len) : rp_sum;
  assign rp      = rp_wrap[PW-1:0];
  assign prev    = (rp == '0) ? PW'(eff_len - NW'(1)) : rp - PW'(1);

  // first read is issued in the accept cycle, second one right after
  assign raddr = (state_r == S_IDLE) ? rp : prev_r;

  // entries past the fill count were never written and read as zero
  assign b_val = b_ok_r ? rdata : '0;
  assign diff  = {b_val[SW-1], b_val} - {a_r[SW-1], a_r};
  assign blend = {a_r, {FRAC_W{1'b0}}} + prod[MAW-1:0];

  // multiplier operand select
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = {{(MAW-SW-1){diff[SW]}}, diff};
      mul_b = {{(MBW-FRAC_W){1'b0}}, eff_frac};
    end else begin
      mul_a = blend;
      mul_b = {1'b0, gain};
    end
  end

  // round half up, then saturate to the sample width
  assign acc   = prod + ROUND_HALF;
  assign q     = acc[PRW-1:PROD_SHIFT];
  assign q_top = q[QW-1:SW-1];
  assign q_sat = ((&q_top) || !(|q_top)) ? q[SW-1:0] : (q[QW-1] ? SAT_NEG : SAT_POS);

  assign out_free = !out_valid_r || out_ready;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_eff;
    fill_nxt      = fill_r;
    prev_nxt      = prev_r;
    a_ok_nxt      = a_ok_r;
    b_ok_nxt      = b_ok_r;
    sample_nxt    = sample_r;
    a_nxt         = a_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    mul_en        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample_in;
          prev_nxt   = prev;
          a_ok_nxt   = NW'(rp) < fill_r;
          state_nxt  = S_RDB;
        end
      end
      S_RDB: begin
        a_nxt     = a_ok_r ? rdata : '0;
        b_ok_nxt  = NW'(prev_r) < fill_r;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mul_en = 1'b1;
        ram_we = 1'b1;
        wp_nxt = (NW'(wp_eff) + NW'(1) >= eff_len) ? '0 : wp_eff + PW'(1);
        if (NW'(wp_eff) >= fill_r) begin
          fill_nxt = NW'(wp_eff) + NW'(1);
        end
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        mul_en    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_nxt       = q_sat;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prev_r   <= prev_nxt;
    a_ok_r   <= a_ok_nxt;
    b_ok_r   <= b_ok_nxt;
    sample_r <= sample_nxt;
    a_r      <= a_nxt;
    out_r    <= out_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  // checks
  `FDL_ASSERT_NOW(a_read_in_line, state_r == S_IDLE, NW'(rp) < eff_len, "read position past line end")
  `FDL_ASSERT_NOW(a_prev_in_line, state_r == S_RDB, NW'(prev_r) < eff_len, "previous position past line end")
  `FDL_ASSERT_NOW(a_wp_in_fill, 1'b1, NW'(wp_eff) <= fill_r && fill_r <= NW'(MAX_DEPTH), "write position beyond fill count")
  `FDL_ASSERT_NEXT(a_out_load, state_r == S_OUT && out_free, out_valid_r && state_r == S_IDLE, "result beat not loaded")

endmodule

// ===== rtl/fractional_delay_line.sv =====
// Fractional delay line with linear interpolation and make-up gain. For
// each input sample the accept cycle issues the read of the delayed
// entry, the next cycle reads the entry before it on the store's single
// read port, and the one shared multiplier is then used twice (fraction
// blend, then gain) before rounding and saturation; a stalled output
// holds the result until the output register frees. A new sample is
// taken only when the previous one is finished. The store needs no
// clearing pass after reset: a fill count tracks the entries written
// since reset and anything beyond it reads as zero. Registers are to be
// written only while the block is idle; the block does not enforce it.
// depends on fdl_pkg, fdl_regs, fdl_core
module fractional_delay_line #(
  parameter int MAX_DEPTH    = fdl_pkg::DEF_MAX_DEPTH,
  parameter int SAMPLE_WIDTH = fdl_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fdl_pkg::PADDR_W-1:0]     paddr,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fdl_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SAMPLE_WIDTH-1:0]         in_sample_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SAMPLE_WIDTH-1:0]         out_sample_out
);

  import fdl_pkg::*;

  localparam int NW = $clog2(MAX_DEPTH) + 1;

  logic [NW-1:0]     eff_len;
  logic [NW-1:0]     eff_whole;
  logic [FRAC_W-1:0] eff_frac;
  logic [GAIN_W-1:0] gain;

  // configuration registers
  fdl_regs #(
    .MAX_DEPTH(MAX_DEPTH),
    .NW       (NW)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .eff_len  (eff_len),
    .eff_whole(eff_whole),
    .eff_frac (eff_frac),
    .gain     (gain)
  );

  // store, sequencer and arithmetic
  fdl_core #(
    .MAX_DEPTH   (MAX_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .NW          (NW)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .eff_len       (eff_len),
    .eff_whole     (eff_whole),
    .eff_frac      (eff_frac),
    .gain          (gain)
  );

endmodule
